### design/cra_pkg.sv
// Shared constants, types and helpers for the compacting region allocator.
`timescale 1ns / 1ps

package cra_pkg;

  localparam int unsigned STORE_CAPACITY = 1024;
  localparam int unsigned OWNER_SLOTS    = 32;

  // Fixed field widths of the request and result transfers
  localparam int unsigned REQ_TYPE_W  = 1;
  localparam int unsigned OWNER_W     = 5;
  localparam int unsigned LENGTH_W    = 11;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned COPY_ADDR_W = 10;
  localparam int unsigned COPY_LEN_W  = 11;
  localparam int unsigned GRANT_W     = 11;

  // Derived widths
  localparam int unsigned SLOT_W = $clog2(OWNER_SLOTS);
  localparam int unsigned POS_W  = $clog2(STORE_CAPACITY + 1);
  localparam int unsigned SUM_W  = ((POS_W > LENGTH_W) ? POS_W : LENGTH_W) + 1;

  localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC   = 1'b0;
  localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_COPY    = 2'd0,
    KIND_GRANT   = 2'd1,
    KIND_REFUSE  = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_e;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef struct packed {
    kind_e                  kind;
    logic [COPY_ADDR_W-1:0] copy_source;
    logic [COPY_ADDR_W-1:0] copy_dest;
    logic [COPY_LEN_W-1:0]  copy_length;
    logic [GRANT_W-1:0]     granted_start;
    logic                   last;
  } res_t;

  // Region table write port
  typedef struct packed {
    logic  en;
    slot_t idx;
    pos_t  start;
    pos_t  len;
  } tbl_wr_t;

  // Min-search unit controls
  typedef struct packed {
    logic clr_done;
    logic clr_best;
    logic step;
    logic mark;
  } scan_ctl_t;

  // Current lowest-start candidate
  typedef struct packed {
    logic  found;
    slot_t idx;
    pos_t  start;
    pos_t  len;
  } best_t;

  function automatic res_t make_res(kind_e kind, pos_t src, pos_t dst, pos_t len,
                                    pos_t granted, logic last);
    res_t r;
    r.kind          = kind;
    r.copy_source   = COPY_ADDR_W'(src);
    r.copy_dest     = COPY_ADDR_W'(dst);
    r.copy_length   = COPY_LEN_W'(len);
    r.granted_start = GRANT_W'(granted);
    r.last          = last;
    return r;
  endfunction

endpackage

### design/cra_req_if.sv
// Request channel interface: valid/ready plus request payload.
`timescale 1ns / 1ps

interface cra_req_if import cra_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [OWNER_W-1:0]    owner;
  logic [LENGTH_W-1:0]   length;

  modport source (output valid, req_type, owner, length, input ready);
  modport sink   (input valid, req_type, owner, length, output ready);
endinterface

### design/cra_res_if.sv
// Result channel interface: valid/ready plus result payload.
`timescale 1ns / 1ps

interface cra_res_if import cra_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      kind;
  logic [COPY_ADDR_W-1:0] copy_source;
  logic [COPY_ADDR_W-1:0] copy_dest;
  logic [COPY_LEN_W-1:0]  copy_length;
  logic [GRANT_W-1:0]     granted_start;
  logic                   last;

  modport source (output valid, kind, copy_source, copy_dest, copy_length,
                  granted_start, last, input ready);
  modport sink   (input valid, kind, copy_source, copy_dest, copy_length,
                  granted_start, last, output ready);
endinterface

### design/cra_table.sv
// Per-owner region table: start and length registers, one read and one write port.
`timescale 1ns / 1ps

module cra_table import cra_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  slot_t   rd_idx_i,
  output pos_t    rd_start_o,
  output pos_t    rd_len_o,
  input  tbl_wr_t wr_i
);

  pos_t start_q [OWNER_SLOTS];
  pos_t len_q   [OWNER_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < OWNER_SLOTS; i++) begin
        start_q[i] <= '0;
        len_q[i]   <= '0;
      end
    end else if (wr_i.en) begin
      start_q[wr_i.idx] <= wr_i.start;
      len_q[wr_i.idx]   <= wr_i.len;
    end
  end

  assign rd_start_o = start_q[rd_idx_i];
  assign rd_len_o   = len_q[rd_idx_i];

endmodule

### design/cra_scan.sv
// Shared min-search unit: one start compare per cycle, placed-owner flags.
`timescale 1ns / 1ps

module cra_scan import cra_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_ctl_t ctl_i,
  input  slot_t     idx_i,
  input  pos_t      start_i,
  input  pos_t      len_i,
  output best_t     best_o
);

  logic [OWNER_SLOTS-1:0] done_q, done_d;
  best_t                  best_q, best_d;
  logic                   take;

  // Candidate: live, not yet placed, lower start (strict, so ties keep lower slot)
  assign take = (len_i != '0) && !done_q[idx_i] && (!best_q.found || (start_i < best_q.start));

  always_comb begin
    done_d = done_q;
    best_d = best_q;
    if (ctl_i.clr_done) begin
      done_d = '0;
    end
    if (ctl_i.mark) begin
      done_d[best_q.idx] = 1'b1;
    end
    if (ctl_i.clr_best) begin
      best_d.found = 1'b0;
    end
    if (ctl_i.step && take) begin
      best_d.found = 1'b1;
      best_d.idx   = idx_i;
      best_d.start = start_i;
      best_d.len   = len_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
      best_q <= '0;
    end else begin
      done_q <= done_d;
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

endmodule

### design/cra_out_reg.sv
// Result output register: holds one result while the receiver stalls.
`timescale 1ns / 1ps

module cra_out_reg import cra_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  res_t   res_i,
  output logic   free_o,
  cra_res_if.source res_o
);

  logic valid_q;
  res_t res_q;

  assign free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.kind          = res_q.kind;
  assign res_o.copy_source   = res_q.copy_source;
  assign res_o.copy_dest     = res_q.copy_dest;
  assign res_o.copy_length   = res_q.copy_length;
  assign res_o.granted_start = res_q.granted_start;
  assign res_o.last          = res_q.last;

endmodule

### design/compacting_region_allocator.sv
// Top level: bump allocator with sliding compaction under a small sequencer.
`timescale 1ns / 1ps

// Usage
//   req_i  : one transfer per request (allocate or release for an owner slot).
//   res_o  : one or more result transfers per request; the final one has last set.
//            Copy commands from a compaction come first, then grant/refuse.
// Sequence (states in order)
//   release                 : IDLE, where the slot's table entry clears, then EMIT.
//   allocate, fits          : IDLE, CHECK, then EMIT with the grant.
//   allocate, needs compact : CHECK, a SCAN and PLACE pass per held region and
//                             a closing pass, an EMIT after each PLACE that
//                             moves a region, then CHECK again. Each pass
//                             walks every slot through one shared start
//                             comparator to find the next-lowest region.
//   req_i.ready is high only while the sequencer is idle.
// Reset: all regions and the bump pointer clear at once (asynchronous, active low).
// Stall: one result waits in the output register; the sequencer waits with the
//   next result until that register frees, so nothing is dropped.
module compacting_region_allocator import cra_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  cra_req_if.sink   req_i,
  cra_res_if.source res_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [OWNER_W-1:0]  owner_q, owner_d;
  logic [LENGTH_W-1:0] len_q, len_d;
  pos_t                bump_q, bump_d;
  pos_t                cursor_q, cursor_d;
  slot_t               idx_q, idx_d;
  logic                compacted_q, compacted_d;
  res_t                pend_q, pend_d;

  tbl_wr_t   tbl_wr;
  pos_t      rd_start, rd_len;
  scan_ctl_t scan_ctl;
  best_t     best;
  logic      out_free, push;
  logic      req_fire;
  logic      owner_ok;
  logic      fits;
  pos_t      next_cursor;

  cra_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (idx_q),
    .rd_start_o(rd_start),
    .rd_len_o  (rd_len),
    .wr_i      (tbl_wr)
  );

  cra_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (scan_ctl),
    .idx_i  (idx_q),
    .start_i(rd_start),
    .len_i  (rd_len),
    .best_o (best)
  );

  cra_out_reg u_out (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .res_i (pend_q),
    .free_o(out_free),
    .res_o (res_o)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  assign owner_ok    = 32'(owner_q) < OWNER_SLOTS;
  assign fits        = (SUM_W'(bump_q) + SUM_W'(len_q)) <= SUM_W'(STORE_CAPACITY);
  assign next_cursor = cursor_q + best.len;

  always_comb begin
    state_d     = state_q;
    owner_d     = owner_q;
    len_d       = len_q;
    bump_d      = bump_q;
    cursor_d    = cursor_q;
    idx_d       = idx_q;
    compacted_d = compacted_q;
    pend_d      = pend_q;
    tbl_wr      = '0;
    scan_ctl    = '0;
    push        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          if (req_i.req_type == REQ_RELEASE) begin
            // Out-of-range slot answers release done with no change
            tbl_wr.en    = 32'(req_i.owner) < OWNER_SLOTS;
            tbl_wr.idx   = SLOT_W'(req_i.owner);
            pend_d       = make_res(KIND_RELEASE, '0, '0, '0, '0, 1'b1);
            state_d      = S_EMIT;
          end else begin
            owner_d     = req_i.owner;
            len_d       = req_i.length;
            compacted_d = 1'b0;
            state_d     = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        if (!owner_ok) begin
          pend_d  = make_res(KIND_REFUSE, '0, '0, '0, '0, 1'b1);
          state_d = S_EMIT;
        end else if (fits) begin
          tbl_wr.en    = 1'b1;
          tbl_wr.idx   = SLOT_W'(owner_q);
          tbl_wr.start = bump_q;
          tbl_wr.len   = POS_W'(len_q);
          pend_d       = make_res(KIND_GRANT, '0, '0, '0, bump_q, 1'b1);
          bump_d       = bump_q + POS_W'(len_q);
          state_d      = S_EMIT;
        end else if (!compacted_q) begin
          // Start compaction: fresh placed flags, cursor at the store base
          compacted_d       = 1'b1;
          cursor_d          = '0;
          idx_d             = '0;
          scan_ctl.clr_done = 1'b1;
          scan_ctl.clr_best = 1'b1;
          state_d           = S_SCAN;
        end else begin
          pend_d  = make_res(KIND_REFUSE, '0, '0, '0, '0, 1'b1);
          state_d = S_EMIT;
        end
      end

      S_SCAN: begin
        // One slot per cycle through the shared comparator
        scan_ctl.step = 1'b1;
        if (idx_q == SLOT_W'(OWNER_SLOTS - 1)) begin
          state_d = S_PLACE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_PLACE: begin
        idx_d = '0;
        if (!best.found) begin
          // Every live region placed; free space begins at the cursor
          bump_d  = cursor_q;
          state_d = S_CHECK;
        end else begin
          scan_ctl.mark     = 1'b1;
          scan_ctl.clr_best = 1'b1;
          cursor_d          = next_cursor;
          if (best.start != cursor_q) begin
            tbl_wr.en    = 1'b1;
            tbl_wr.idx   = best.idx;
            tbl_wr.start = cursor_q;
            tbl_wr.len   = best.len;
            pend_d       = make_res(KIND_COPY, best.start, cursor_q, best.len, '0, 1'b0);
            state_d      = S_EMIT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          push    = 1'b1;
          state_d = pend_q.last ? S_IDLE : S_SCAN;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bump_q      <= '0;
      cursor_q    <= '0;
      idx_q       <= '0;
      compacted_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bump_q      <= bump_d;
      cursor_q    <= cursor_d;
      idx_q       <= idx_d;
      compacted_q <= compacted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    owner_q <= owner_d;
    len_q   <= len_d;
    pend_q  <= pend_d;
  end

endmodule

### design/cra_checker.sv
// Port-level assertions for the allocator, bound to the top level.
`timescale 1ns / 1ps

module cra_checker import cra_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   req_valid_i,
  input logic                   req_ready_i,
  input logic                   res_valid_i,
  input logic                   res_ready_i,
  input logic [KIND_W-1:0]      res_kind_i,
  input logic [COPY_ADDR_W-1:0] copy_source_i,
  input logic [COPY_ADDR_W-1:0] copy_dest_i,
  input logic [COPY_LEN_W-1:0]  copy_length_i,
  input logic [GRANT_W-1:0]     granted_start_i,
  input logic                   last_i
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_kind_i)
      && $stable(copy_source_i) && $stable(copy_dest_i) && $stable(copy_length_i)
      && $stable(granted_start_i) && $stable(last_i))
    else $error("stalled result changed");

  // Busy after each accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // A pending copy means compaction is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == KIND_COPY) |-> !req_ready_i)
    else $error("idle with copy command outstanding");

  // Copies slide down and never end a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == KIND_COPY) |-> (copy_dest_i < copy_source_i) && !last_i)
    else $error("bad copy command");

endmodule

bind compacting_region_allocator cra_checker u_cra_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .res_kind_i     (res_o.kind),
  .copy_source_i  (res_o.copy_source),
  .copy_dest_i    (res_o.copy_dest),
  .copy_length_i  (res_o.copy_length),
  .granted_start_i(res_o.granted_start),
  .last_i         (res_o.last)
);

### dv/compacting_region_allocator_tb.sv
// Self-checking testbench for the compacting region allocator.
`timescale 1ns / 1ps

module compacting_region_allocator_tb;
  import cra_pkg::*;

  // Cycles with no transfer on either channel before the run is declared hung.
  // The slowest legal stretch is one full compaction scan of a packed store
  // plus a receiver stall.
  localparam int unsigned IDLE_LIMIT   = 8000;
  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PRINT_CAP    = 40;

  // Shadow copy of the region table. It works out, for each request, the
  // transfers the block must emit and holds them until they show up.
  class region_ledger;
    logic [LENGTH_W-1:0] start_tbl[OWNER_SLOTS];
    logic [LENGTH_W-1:0] length_tbl[OWNER_SLOTS];
    int unsigned         bump;
    res_t                awaited_results[$];
    int unsigned         mismatches;

    function new();
      for (int s = 0; s < OWNER_SLOTS; s++) begin
        start_tbl[s]  = '0;
        length_tbl[s] = '0;
      end
      bump       = 0;
      mismatches = 0;
    endfunction

    function void report(string msg);
      if (mismatches < PRINT_CAP) begin
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      mismatches++;
    endfunction

    function void push_result(kind_e kind, int unsigned src, int unsigned dst,
                              int unsigned len, int unsigned granted, logic last);
      res_t r;
      r.kind          = kind;
      r.copy_source   = src[COPY_ADDR_W-1:0];
      r.copy_dest     = dst[COPY_ADDR_W-1:0];
      r.copy_length   = len[COPY_LEN_W-1:0];
      r.granted_start = granted[GRANT_W-1:0];
      r.last          = last;
      awaited_results.push_back(r);
    endfunction

    // Slide every live region down to a running cursor, lowest start first
    // (lowest slot wins a tie), one copy command per region that moves.
    function void slide_regions_down();
      bit          taken[OWNER_SLOTS];
      int          best;
      int unsigned cursor;
      cursor = 0;
      for (int s = 0; s < OWNER_SLOTS; s++) taken[s] = 1'b0;
      do begin
        best = -1;
        for (int s = 0; s < OWNER_SLOTS; s++) begin
          if (length_tbl[s] != 0 && !taken[s] &&
              (best < 0 || start_tbl[s] < start_tbl[best])) begin
            best = s;
          end
        end
        if (best >= 0) begin
          taken[best] = 1'b1;
          if (start_tbl[best] != cursor) begin
            push_result(KIND_COPY, start_tbl[best], cursor, length_tbl[best], 0, 1'b0);
            start_tbl[best] = cursor[LENGTH_W-1:0];
          end
          cursor += length_tbl[best];
        end
      end while (best >= 0);
      bump = cursor;
    endfunction

    function void note_request(logic [REQ_TYPE_W-1:0] req_type, logic [OWNER_W-1:0] owner,
                               logic [LENGTH_W-1:0] len);
      if (req_type == REQ_RELEASE) begin
        if (owner < OWNER_SLOTS) begin
          start_tbl[owner]  = '0;
          length_tbl[owner] = '0;
        end
        push_result(KIND_RELEASE, 0, 0, 0, 0, 1'b1);
        return;
      end
      if (owner >= OWNER_SLOTS) begin
        push_result(KIND_REFUSE, 0, 0, 0, 0, 1'b1);
        return;
      end
      if (bump + len > STORE_CAPACITY) slide_regions_down();
      if (bump + len > STORE_CAPACITY) begin
        // refused: compaction stands, owner keeps whatever it had
        push_result(KIND_REFUSE, 0, 0, 0, 0, 1'b1);
        return;
      end
      start_tbl[owner]  = bump[LENGTH_W-1:0];
      length_tbl[owner] = len;
      push_result(KIND_GRANT, 0, 0, 0, bump, 1'b1);
      bump += len;
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("result kind %0d arrived with nothing pending", got.kind));
        return;
      end
      want = awaited_results.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.copy_source !== want.copy_source)
        report($sformatf("copy_source %0d, want %0d", got.copy_source, want.copy_source));
      if (got.copy_dest !== want.copy_dest)
        report($sformatf("copy_dest %0d, want %0d", got.copy_dest, want.copy_dest));
      if (got.copy_length !== want.copy_length)
        report($sformatf("copy_length %0d, want %0d", got.copy_length, want.copy_length));
      if (got.granted_start !== want.granted_start)
        report($sformatf("granted_start %0d, want %0d", got.granted_start,
                         want.granted_start));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endfunction

    // Mostly pick a slot that really holds a region, so releases punch holes.
    function logic [OWNER_W-1:0] pick_held_owner();
      int unsigned held[$];
      for (int s = 0; s < OWNER_SLOTS; s++) begin
        if (length_tbl[s] != 0) held.push_back(s);
      end
      if (held.size() == 0) return OWNER_W'($urandom_range(0, OWNER_SLOTS - 1));
      return OWNER_W'(held[$urandom_range(0, held.size() - 1)]);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  cra_req_if req_if ();
  cra_res_if res_if ();

  compacting_region_allocator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  region_ledger ledger;

  // Sender burst state: a burst of back-to-back requests, then a random gap.
  int unsigned burst_left;
  bit          no_gap_phase;
  bit          stimulus_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Every input known from time zero.
  initial begin
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_ALLOC;
    req_if.owner     = '0;
    req_if.length    = '0;
    res_if.ready     = 1'b0;
  end

  // Drive one request at the falling edge, hold it until the transfer, then
  // hand it to the ledger. Gaps only open between bursts, so valid never
  // drops and rises inside one time step.
  task automatic send_request(logic [REQ_TYPE_W-1:0] req_type, logic [OWNER_W-1:0] owner,
                              logic [LENGTH_W-1:0] len);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap        = no_gap_phase ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        req_if.valid  = 1'b0;
        req_if.owner  = OWNER_W'($urandom);
        req_if.length = LENGTH_W'($urandom);
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_if.valid    = 1'b1;
    req_if.req_type = req_type;
    req_if.owner    = owner;
    req_if.length   = len;
    do @(posedge clk_i); while (!req_if.ready);
    ledger.note_request(req_type, owner, len);
  endtask

  // Mostly small regions so the store fills over a dozen or so grants;
  // a few big ones and a few past capacity.
  function automatic logic [LENGTH_W-1:0] pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)  return '0;
    if (roll < 75) return LENGTH_W'($urandom_range(1, 64));
    if (roll < 90) return LENGTH_W'($urandom_range(65, 400));
    if (roll < 97) return LENGTH_W'($urandom_range(401, STORE_CAPACITY));
    return LENGTH_W'($urandom_range(STORE_CAPACITY + 1, (1 << LENGTH_W) - 1));
  endfunction

  // Hand-picked walk through the corner cases. Comments give the expected
  // outcome of a step and, for some steps, the bump pointer after it.
  task automatic run_directed();
    send_request(REQ_ALLOC,   5'd0,  11'd0);     // zero length, granted at 0
    send_request(REQ_ALLOC,   5'd31, 11'd1);     // bump 1
    send_request(REQ_ALLOC,   5'd1,  11'd100);   // bump 101
    send_request(REQ_ALLOC,   5'd2,  11'd200);   // bump 301
    send_request(REQ_RELEASE, 5'd31, 11'd2047);  // hole at 0, length ignored
    send_request(REQ_RELEASE, 5'd5,  11'd0);     // slot never used
    send_request(REQ_ALLOC,   5'd3,  11'd723);   // fills store exactly, bump 1024
    send_request(REQ_ALLOC,   5'd4,  11'd0);     // zero length granted at capacity
    // owner 1 already holds a region: compaction slides all three down,
    // still short, refused
    send_request(REQ_ALLOC,   5'd1,  11'd50);
    send_request(REQ_ALLOC,   5'd6,  11'd1);     // last free entry, bump 1024
    send_request(REQ_ALLOC,   5'd7,  11'd2047);  // above capacity
    send_request(REQ_ALLOC,   5'd7,  11'd1024);  // full capacity while occupied
    send_request(REQ_RELEASE, 5'd3,  11'd0);
    send_request(REQ_ALLOC,   5'd8,  11'd1024);  // compaction moves owner 6, refused
    send_request(REQ_ALLOC,   5'd8,  11'd700);   // fits after that compaction
    send_request(REQ_RELEASE, 5'd2,  11'd0);
    send_request(REQ_ALLOC,   5'd9,  11'd223);   // compaction then grant at 801
    send_request(REQ_ALLOC,   5'd1,  11'd10);    // compacts, nothing moves, refused; owner 1 keeps its region
    for (int s = 0; s < OWNER_SLOTS; s += 8) begin
      send_request(REQ_RELEASE, OWNER_W'(s + 1), 11'd0);
    end
    send_request(REQ_ALLOC,   5'd31, 11'd1024);  // compacts, then decided by what is left
  endtask

  task automatic run_random();
    int unsigned roll;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // a stretch with the sender never idling
      no_gap_phase = (n >= 120 && n < 180);
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        send_request(REQ_ALLOC, OWNER_W'($urandom), pick_length());
      end else if (roll < 88) begin
        send_request(REQ_RELEASE, ledger.pick_held_owner(), LENGTH_W'($urandom));
      end else begin
        // noise: release of any slot, held or not
        send_request(REQ_RELEASE, OWNER_W'($urandom), LENGTH_W'($urandom));
      end
    end
  endtask

  // Receiver stall pattern: phases of always-ready, occasional short stalls
  // and frequent long stalls, taken in turn.
  initial begin : result_backpressure
    int unsigned cycle_cnt;
    int unsigned stall_left;
    int unsigned phase;
    cycle_cnt  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      cycle_cnt++;
      phase = (cycle_cnt / 300) % 3;
      if (stall_left > 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else if (phase == 1 && $urandom_range(0, 99) < 10) begin
        res_if.ready = 1'b0;
        stall_left   = $urandom_range(0, 3);
      end else if (phase == 2 && $urandom_range(0, 99) < 30) begin
        res_if.ready = 1'b0;
        stall_left   = $urandom_range(0, 15);
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  // Result monitor: compare each transfer with the oldest pending expectation.
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.kind          = kind_e'(res_if.kind);
      got.copy_source   = res_if.copy_source;
      got.copy_dest     = res_if.copy_dest;
      got.copy_length   = res_if.copy_length;
      got.granted_start = res_if.granted_start;
      got.last          = res_if.last;
      ledger.check_result(got);
    end
  end

  // Hang detector: any transfer on either channel, or the end of stimulus, restarts the count.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || stimulus_done)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : main_sequence
    ledger        = new();
    burst_left    = 0;
    no_gap_phase  = 1'b0;
    stimulus_done = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    run_random();

    @(negedge clk_i);
    req_if.valid = 1'b0;

    // drain: the watchdog still guards a result that never comes
    while (ledger.awaited_results.size() != 0) @(posedge clk_i);
    stimulus_done = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ledger.awaited_results.size() != 0)
      ledger.report($sformatf("%0d results never arrived", ledger.awaited_results.size()));

    if (ledger.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
design/cra_pkg.sv
design/cra_req_if.sv
design/cra_res_if.sv
design/cra_table.sv
design/cra_scan.sv
design/cra_out_reg.sv
design/compacting_region_allocator.sv
design/cra_checker.sv
dv/compacting_region_allocator_tb.sv
